>>> rtl/core/ranm_pkg.sv
// ----------------------------------------------------------------------------
// ranm_pkg
// shared constants of the rational add/multiply/normalize unit
// ----------------------------------------------------------------------------
package ranm_pkg;

    localparam int OPERAND_BITS_DEF = 16;
    localparam int RES_NUM_W = 32;
    localparam int RES_DEN_W = 30;
    localparam int ACT_W = 2;

    localparam logic [ACT_W-1:0] ACT_ADD = 2'd0;
    localparam logic [ACT_W-1:0] ACT_MUL = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CMP = 2'd2;
    localparam logic [ACT_W-1:0] ACT_RSV = 2'd3;

    // sequencer steps shared by controller and datapath
    localparam logic [3:0] S_LOAD = 4'd0;
    localparam logic [3:0] S_GCD1 = 4'd1;
    localparam logic [3:0] S_LCD  = 4'd2;
    localparam logic [3:0] S_Q1   = 4'd3;
    localparam logic [3:0] S_Q2   = 4'd4;
    localparam logic [3:0] S_P1   = 4'd5;
    localparam logic [3:0] S_P2   = 4'd6;
    localparam logic [3:0] S_SUM  = 4'd7;
    localparam logic [3:0] S_MULN = 4'd8;
    localparam logic [3:0] S_MULD = 4'd9;
    localparam logic [3:0] S_SIGN = 4'd10;
    localparam logic [3:0] S_GCD2 = 4'd11;
    localparam logic [3:0] S_DN   = 4'd12;
    localparam logic [3:0] S_DD   = 4'd13;
    localparam logic [3:0] S_FIN  = 4'd14;
    localparam logic [3:0] S_IDLE = 4'd15;

endpackage

>>> rtl/core/ranm_if.sv
// ----------------------------------------------------------------------------
// ranm_if
// valid/ready channel carrying one word of payload type t_word
// ----------------------------------------------------------------------------
interface ranm_if #(
    parameter type t_word = logic
);
    logic  valid;
    logic  ready;
    t_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/ranm_dp.sv
// ----------------------------------------------------------------------------
// ranm_dp
// datapath: operand registers, one multiplier, a shared bit-serial divider
// ----------------------------------------------------------------------------
module ranm_dp #(
    parameter int OPERAND_BITS = ranm_pkg::OPERAND_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [3:0]                 i_step,
    input  logic                       i_step_go,
    input  logic [OPERAND_BITS-1:0]    i_num_a,
    input  logic [OPERAND_BITS-2:0]    i_den_a,
    input  logic [OPERAND_BITS-1:0]    i_num_b,
    input  logic [OPERAND_BITS-2:0]    i_den_b,
    output logic                       o_step_done,
    output logic                       o_gcd_zero,
    output logic [63:0]                o_num,
    output logic [63:0]                o_den,
    output logic                       o_neg
);
    logic [63:0] r_na, r_nb, r_da, r_db, r_g, r_lcd, r_q1, r_q2, r_p1, r_num, r_den;
    logic        r_neg;
    // divider: r_dvd / r_dvs -> r_quo, r_rem
    logic [63:0] r_dvd, r_dvs, r_quo, r_rem;
    logic [6:0]  r_cnt;
    logic        r_div_busy;
    // gcd loop
    logic [63:0] r_ga, r_gb;
    logic        r_gcd_busy;
    logic [1:0]  r_phase;
    logic        r_done;

    logic [64:0]        w_trial;
    logic [63:0]        w_rsh;
    logic signed [31:0] w_ma, w_mb;
    logic signed [63:0] w_prod;

    assign w_rsh   = {r_rem[62:0], r_dvd[63]};
    assign w_trial = {1'b0, w_rsh} - {1'b0, r_dvs};

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (i_step)
            ranm_pkg::S_Q1:   begin w_ma = r_quo[31:0]; w_mb = r_db[31:0]; end
            ranm_pkg::S_P1:   begin w_ma = r_na[31:0]; w_mb = r_q1[31:0]; end
            ranm_pkg::S_P2:   begin w_ma = r_nb[31:0]; w_mb = r_q2[31:0]; end
            ranm_pkg::S_MULN: begin w_ma = r_na[31:0]; w_mb = r_nb[31:0]; end
            ranm_pkg::S_MULD: begin w_ma = r_da[31:0]; w_mb = r_db[31:0]; end
            default:          begin w_ma = '0; w_mb = '0; end
        endcase
    end
    assign w_prod = w_ma * w_mb;

    function automatic logic [63:0] sext(input logic [OPERAND_BITS-1:0] v);
        return {{(64-OPERAND_BITS){v[OPERAND_BITS-1]}}, v};
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_gcd_busy <= 1'b0;
            r_done     <= 1'b0;
            r_phase    <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_div_busy) begin
                r_dvd <= {r_dvd[62:0], 1'b0};
                if (!w_trial[64]) begin
                    r_rem <= w_trial[63:0];
                    r_quo <= {r_quo[62:0], 1'b1};
                end else begin
                    r_rem <= w_rsh;
                    r_quo <= {r_quo[62:0], 1'b0};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) r_div_busy <= 1'b0;
            end else if (r_gcd_busy) begin
                // phase 0: test b, start a%b; phase 1: rotate
                if (r_phase == 2'd0) begin
                    if (r_gb == '0) begin
                        r_g        <= r_ga;
                        r_gcd_busy <= 1'b0;
                        r_done     <= 1'b1;
                    end else begin
                        r_dvd <= r_ga; r_dvs <= r_gb; r_rem <= '0;
                        r_cnt <= 7'd64; r_div_busy <= 1'b1; r_phase <= 2'd1;
                    end
                end else begin
                    r_ga <= r_gb; r_gb <= r_rem; r_phase <= 2'd0;
                end
            end else if (r_phase == 2'd2) begin
                r_phase <= 2'd0;
                r_done  <= 1'b1;
            end else if (i_step_go) begin
                unique case (i_step)
                    ranm_pkg::S_LOAD: begin
                        r_na <= sext(i_num_a);
                        r_nb <= sext(i_num_b);
                        r_da <= 64'(i_den_a);
                        r_db <= 64'(i_den_b);
                        r_done <= 1'b1;
                    end
                    ranm_pkg::S_GCD1: begin
                        r_ga <= r_da; r_gb <= r_db; r_gcd_busy <= 1'b1;
                    end
                    ranm_pkg::S_LCD: begin
                        r_dvd <= r_da; r_dvs <= r_g; r_rem <= '0; r_cnt <= 7'd64;
                        r_div_busy <= 1'b1; r_phase <= 2'd2;
                    end
                    ranm_pkg::S_Q1: begin
                        // lcd = (da/g)*db, q2 = da/g, then q1 = db/g
                        r_lcd <= w_prod;
                        r_q2  <= r_quo;
                        r_dvd <= r_db; r_dvs <= r_g; r_rem <= '0; r_cnt <= 7'd64;
                        r_div_busy <= 1'b1; r_phase <= 2'd2;
                    end
                    ranm_pkg::S_Q2: begin
                        r_q1 <= r_quo;
                        r_done <= 1'b1;
                    end
                    ranm_pkg::S_P1: begin
                        r_p1 <= w_prod; r_done <= 1'b1;
                    end
                    ranm_pkg::S_P2: begin
                        r_num <= r_p1 + w_prod; r_done <= 1'b1;
                    end
                    ranm_pkg::S_SUM: begin
                        r_den <= r_lcd; r_done <= 1'b1;
                    end
                    ranm_pkg::S_MULN: begin
                        r_num <= w_prod; r_done <= 1'b1;
                    end
                    ranm_pkg::S_MULD: begin
                        r_den <= w_prod; r_done <= 1'b1;
                    end
                    ranm_pkg::S_SIGN: begin
                        r_neg <= r_num[63];
                        r_num <= r_num[63] ? 64'd0 - r_num : r_num;
                        r_done <= 1'b1;
                    end
                    ranm_pkg::S_GCD2: begin
                        r_ga <= r_num; r_gb <= r_den; r_gcd_busy <= 1'b1;
                    end
                    ranm_pkg::S_DN: begin
                        r_dvd <= r_num; r_dvs <= r_g; r_rem <= '0; r_cnt <= 7'd64;
                        r_div_busy <= 1'b1; r_phase <= 2'd2;
                    end
                    ranm_pkg::S_DD: begin
                        r_num <= r_quo;
                        r_dvd <= r_den; r_dvs <= r_g; r_rem <= '0; r_cnt <= 7'd64;
                        r_div_busy <= 1'b1; r_phase <= 2'd2;
                    end
                    default: r_done <= 1'b1;
                endcase
            end
        end
    end

    assign o_step_done = r_done;
    assign o_gcd_zero  = (r_num == '0) || (r_den == '0);
    assign o_num       = r_num;
    assign o_den       = r_quo;
    assign o_neg       = r_neg;
endmodule

>>> rtl/core/ranm_ctrl.sv
// ----------------------------------------------------------------------------
// ranm_ctrl
// sequencer stepping the datapath through add, multiply or compare
// ----------------------------------------------------------------------------
module ranm_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [ranm_pkg::ACT_W-1:0] i_action,
    input  logic                       i_step_done,
    input  logic                       i_zero,
    output logic [3:0]                 o_step,
    output logic                       o_step_go,
    output logic                       o_finish,
    output logic                       o_zero_res,
    input  logic                       i_out_free
);
    logic [3:0] r_step;
    logic       r_wait;
    logic [1:0] r_act;
    logic       r_zero;

    assign o_in_ready = (r_step == ranm_pkg::S_IDLE) && i_out_free;
    assign o_step     = r_step;
    assign o_step_go  = (r_step != ranm_pkg::S_IDLE) && (r_step != ranm_pkg::S_FIN) && !r_wait;
    assign o_finish   = (r_step == ranm_pkg::S_FIN);
    assign o_zero_res = r_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ranm_pkg::S_IDLE;
            r_wait <= 1'b0;
            r_act  <= '0;
            r_zero <= 1'b0;
        end else if (r_step == ranm_pkg::S_IDLE) begin
            if (i_in_valid && o_in_ready) begin
                r_act  <= i_action;
                r_zero <= 1'b0;
                r_step <= ranm_pkg::S_LOAD;
            end
        end else if (r_step == ranm_pkg::S_FIN) begin
            r_step <= ranm_pkg::S_IDLE;
        end else if (!r_wait) begin
            r_wait <= 1'b1;
        end else if (i_step_done) begin
            r_wait <= 1'b0;
            unique case (r_step)
                ranm_pkg::S_LOAD: begin
                    if (r_act == ranm_pkg::ACT_ADD) r_step <= ranm_pkg::S_GCD1;
                    else if (r_act == ranm_pkg::ACT_MUL) r_step <= ranm_pkg::S_MULN;
                    else r_step <= ranm_pkg::S_FIN;
                end
                ranm_pkg::S_GCD1: r_step <= ranm_pkg::S_LCD;
                ranm_pkg::S_LCD:  r_step <= ranm_pkg::S_Q1;
                ranm_pkg::S_Q1:   r_step <= ranm_pkg::S_Q2;
                ranm_pkg::S_Q2:   r_step <= ranm_pkg::S_P1;
                ranm_pkg::S_P1:   r_step <= ranm_pkg::S_P2;
                ranm_pkg::S_P2:   r_step <= ranm_pkg::S_SUM;
                ranm_pkg::S_SUM:  r_step <= ranm_pkg::S_SIGN;
                ranm_pkg::S_MULN: r_step <= ranm_pkg::S_MULD;
                ranm_pkg::S_MULD: r_step <= ranm_pkg::S_SIGN;
                ranm_pkg::S_SIGN: begin
                    if (i_zero) begin
                        r_zero <= 1'b1;
                        r_step <= ranm_pkg::S_FIN;
                    end else r_step <= ranm_pkg::S_GCD2;
                end
                ranm_pkg::S_GCD2: r_step <= ranm_pkg::S_DN;
                ranm_pkg::S_DN:   r_step <= ranm_pkg::S_DD;
                ranm_pkg::S_DD:   r_step <= ranm_pkg::S_FIN;
                default: r_step <= ranm_pkg::S_IDLE;
            endcase
        end
    end
endmodule

>>> rtl/core/rational_add_mult_normalize.sv
// ----------------------------------------------------------------------------
// rational_add_mult_normalize
// rational add, multiply and compare with gcd reduction
//
//   channel  dir  fields
//   in       in   action, num_a, den_a, num_b, den_b
//   out      out  res_num, res_den, is_equal
//
// one word at a time; compare and unused codes finish without a division or gcd;
// every division and each gcd iteration runs on the shared bit-serial divider; add
// runs two gcds and four divisions, multiply one gcd and two divisions, so both
// depend on the gcd iteration count
// reset synchronous active low clears control only
// the result register holds until taken; a new word is taken once it is free
// ----------------------------------------------------------------------------
module rational_add_mult_normalize #(
    parameter int OPERAND_BITS = ranm_pkg::OPERAND_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ranm_if.sink   in_ch,
    ranm_if.source out_ch
);
    logic        w_done, w_zero, w_go, w_fin, w_zres, w_neg;
    logic [3:0]  w_step;
    logic [63:0] w_num, w_den;
    logic        r_ovalid;
    logic [31:0] r_rnum;
    logic [29:0] r_rden;
    logic        r_req;
    logic [1:0]  r_act;
    logic [OPERAND_BITS-1:0] r_na, r_nb;
    logic [OPERAND_BITS-2:0] r_da, r_db;
    logic        w_in_ready;

    assign in_ch.ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (in_ch.valid && w_in_ready) begin
            r_act <= in_ch.data.action;
            r_na  <= OPERAND_BITS'(in_ch.data.num_a);
            r_nb  <= OPERAND_BITS'(in_ch.data.num_b);
            r_da  <= (OPERAND_BITS-1)'(in_ch.data.den_a);
            r_db  <= (OPERAND_BITS-1)'(in_ch.data.den_b);
        end
    end

    ranm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .o_in_ready(w_in_ready),
        .i_action(in_ch.data.action),
        .i_step_done(w_done), .i_zero(w_zero),
        .o_step(w_step), .o_step_go(w_go), .o_finish(w_fin),
        .o_zero_res(w_zres), .i_out_free(!r_ovalid)
    );

    ranm_dp #(.OPERAND_BITS(OPERAND_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_step(w_step), .i_step_go(w_go),
        .i_num_a(r_na), .i_den_a(r_da), .i_num_b(r_nb), .i_den_b(r_db),
        .o_step_done(w_done), .o_gcd_zero(w_zero),
        .o_num(w_num), .o_den(w_den), .o_neg(w_neg)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_fin) begin
            r_ovalid <= 1'b1;
        end else if (out_ch.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin) begin
            if (r_act == ranm_pkg::ACT_CMP) begin
                r_req  <= (r_na == r_nb) && (r_da == r_db);
                r_rnum <= '0; r_rden <= 30'd1;
            end else if (w_zres || r_act == ranm_pkg::ACT_RSV
                || (r_act == ranm_pkg::ACT_ADD && (r_da == '0 || r_db == '0))) begin
                r_req <= 1'b0; r_rnum <= '0; r_rden <= 30'd1;
            end else begin
                r_req  <= 1'b0;
                r_rnum <= w_neg ? 32'(64'd0 - w_num) : w_num[31:0];
                r_rden <= w_den[29:0];
            end
        end
    end

    assign out_ch.valid = r_ovalid;
    assign out_ch.data.res_num  = r_rnum;
    assign out_ch.data.res_den  = r_rden;
    assign out_ch.data.is_equal = r_req;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !in_ch.ready) else $error("accepted with result pending");
    a_fin_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin |=> r_ovalid) else $error("finish lost");
    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && out_ch.data.is_equal) |-> (out_ch.data.res_num == '0))
        else $error("compare numerator nonzero");
endmodule

>>> tb/sv/tb_ranm_types.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ranm_types
// word layouts of the input and result channels at 16-bit operands
// ----------------------------------------------------------------------------
package tb_ranm_types;

    typedef struct packed {
        logic [ranm_pkg::ACT_W-1:0] action;
        logic [15:0]                num_a;
        logic [14:0]                den_a;
        logic [15:0]                num_b;
        logic [14:0]                den_b;
    } t_frac_pair;

    typedef struct packed {
        logic [ranm_pkg::RES_NUM_W-1:0] res_num;
        logic [ranm_pkg::RES_DEN_W-1:0] res_den;
        logic                           is_equal;
    } t_frac_res;

endpackage

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// rational unit check: directed and random fraction pairs are sent with
// random gaps; each accepted pair is reduced by an independent model and the
// results are compared field by field, in order, under random output stalls
// ----------------------------------------------------------------------------
module tb;

    typedef struct {
        tb_ranm_types::t_frac_pair pair;
        bit                        drain;
    } t_send;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ranm_if #(.t_word(tb_ranm_types::t_frac_pair)) in_ch ();
    ranm_if #(.t_word(tb_ranm_types::t_frac_res))  out_ch ();

    rational_add_mult_normalize u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source)
    );

    always #4 i_clk = ~i_clk;

    t_send                    send_q[$];
    tb_ranm_types::t_frac_res reduced_q[$];
    int                       n_err = 0;
    longint                   cyc = 0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        n_err++;
    endtask

    function automatic longint unsigned gcd64(input longint unsigned a, input longint unsigned b);
        longint unsigned t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic tb_ranm_types::t_frac_res reduce(input longint unsigned num,
                                                        input longint unsigned den);
        tb_ranm_types::t_frac_res r;
        bit neg;
        longint unsigned mag, g;
        r = '0;
        r.res_den = 30'd1;
        if (num == 0 || den == 0) return r;
        neg = num[63];
        mag = neg ? -num : num;
        g = gcd64(mag, den);
        mag = mag / g;
        den = den / g;
        r.res_num = neg ? 32'(-mag) : 32'(mag);
        r.res_den = 30'(den);
        return r;
    endfunction

    function automatic tb_ranm_types::t_frac_res predict_frac(
        input tb_ranm_types::t_frac_pair p);
        tb_ranm_types::t_frac_res r;
        longint unsigned na, nb, da, db, g, lcd;
        na = longint'($signed(p.num_a));
        nb = longint'($signed(p.num_b));
        da = 64'(p.den_a);
        db = 64'(p.den_b);
        r = '0;
        r.res_den = 30'd1;
        case (p.action)
            ranm_pkg::ACT_ADD: begin
                if (da != 0 && db != 0) begin
                    g = gcd64(da, db);
                    lcd = (da / g) * db;
                    r = reduce(na * (lcd / da) + nb * (lcd / db), lcd);
                end
            end
            ranm_pkg::ACT_MUL: r = reduce(na * nb, da * db);
            ranm_pkg::ACT_CMP: r.is_equal = (p.num_a == p.num_b) && (da == db);
            default: ;
        endcase
        return r;
    endfunction

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 45) return 0;
        if (k < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // driver
    int gap = 0;
    always @(posedge i_clk) begin
        t_send s;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid) begin
                reduced_q.push_back(predict_frac(in_ch.data));
                gap = pick_gap();
            end
            if (gap > 0 || send_q.size() == 0 ||
                (send_q[0].drain && (reduced_q.size() != 0 || in_ch.valid))) begin
                if (gap > 0) gap--;
                in_ch.valid <= 1'b0;
            end else begin
                s = send_q.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.data  <= s.pair;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        tb_ranm_types::t_frac_res w;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (reduced_q.size() == 0) begin
                    report("unexpected word", 64'(out_ch.data), 64'd0);
                end else begin
                    w = reduced_q.pop_front();
                    if (out_ch.data.res_num !== w.res_num)
                        report("res_num", 64'(out_ch.data.res_num), 64'(w.res_num));
                    if (out_ch.data.res_den !== w.res_den)
                        report("res_den", 64'(out_ch.data.res_den), 64'(w.res_den));
                    if (out_ch.data.is_equal !== w.is_equal)
                        report("is_equal", 64'(out_ch.data.is_equal), 64'(w.is_equal));
                end
            end
            out_ch.ready <= (pick_gap() == 0) || ($urandom_range(0, 1) == 1);
        end
    end

    always @(posedge i_clk) begin
        cyc++;
        if (cyc > 20000000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [15:0] rnd_num();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(int'($urandom_range(0, 40)) - 20);
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [14:0] rnd_den();
        case ($urandom_range(0, 9))
            0: return 15'h7fff;
            1: return 15'($urandom_range(0, 1));
            2, 3: return 15'($urandom_range(1, 64));
            default: return 15'($urandom());
        endcase
    endfunction

    task automatic add_pair(input logic [1:0] a, input logic [15:0] na, input logic [14:0] da,
                            input logic [15:0] nb, input logic [14:0] db, input bit drain = 0);
        t_send s;
        s.pair.action = a;
        s.pair.num_a = na;
        s.pair.den_a = da;
        s.pair.num_b = nb;
        s.pair.den_b = db;
        s.drain = drain;
        send_q.push_back(s);
    endtask

    initial begin
        tb_ranm_types::t_frac_pair p;
        int k;
        // directed: extremes, each action, zero denominators, unused code
        add_pair(ranm_pkg::ACT_ADD, 16'h0001, 15'd2, 16'h0001, 15'd3);
        add_pair(ranm_pkg::ACT_ADD, 16'h8000, 15'h7fff, 16'h8000, 15'h7ffe);
        add_pair(ranm_pkg::ACT_ADD, 16'h7fff, 15'd1, 16'h7fff, 15'd1);
        add_pair(ranm_pkg::ACT_ADD, 16'h0001, 15'd2, 16'hffff, 15'd2);
        add_pair(ranm_pkg::ACT_ADD, 16'h0005, 15'd0, 16'h0003, 15'd4);
        add_pair(ranm_pkg::ACT_ADD, 16'h0005, 15'd6, 16'h0003, 15'd0);
        add_pair(ranm_pkg::ACT_ADD, 16'h0006, 15'd4, 16'h0002, 15'd4);
        add_pair(ranm_pkg::ACT_MUL, 16'h8000, 15'h7fff, 16'h8000, 15'h7fff);
        add_pair(ranm_pkg::ACT_MUL, 16'h7fff, 15'h7fff, 16'h8000, 15'd1);
        add_pair(ranm_pkg::ACT_MUL, 16'h0000, 15'd5, 16'h0007, 15'd3);
        add_pair(ranm_pkg::ACT_MUL, 16'h0004, 15'd0, 16'h0007, 15'd3);
        add_pair(ranm_pkg::ACT_MUL, 16'hfffe, 15'd9, 16'h0003, 15'd4);
        add_pair(ranm_pkg::ACT_CMP, 16'h8000, 15'h7fff, 16'h8000, 15'h7fff);
        add_pair(ranm_pkg::ACT_CMP, 16'h8000, 15'h7fff, 16'h7fff, 15'h7fff);
        add_pair(ranm_pkg::ACT_CMP, 16'h1234, 15'd3, 16'h1234, 15'd4);
        add_pair(ranm_pkg::ACT_CMP, 16'h0000, 15'd0, 16'h0000, 15'd0);
        add_pair(ranm_pkg::ACT_RSV, 16'h7fff, 15'd5, 16'h0001, 15'd5);
        add_pair(ranm_pkg::ACT_RSV, 16'h8000, 15'd0, 16'h8000, 15'h7fff, 1'b1);
        for (int i = 0; i < 540; i++) begin
            k = $urandom_range(0, 99);
            p.action = (k < 40) ? ranm_pkg::ACT_ADD : (k < 75) ? ranm_pkg::ACT_MUL :
                       (k < 95) ? ranm_pkg::ACT_CMP : ranm_pkg::ACT_RSV;
            p.num_a = rnd_num();
            p.den_a = rnd_den();
            p.num_b = rnd_num();
            p.den_b = rnd_den();
            if (p.action == ranm_pkg::ACT_CMP && $urandom_range(0, 1)) begin
                p.num_b = p.num_a;
                if ($urandom_range(0, 2) != 0) p.den_b = p.den_a;
            end
            add_pair(p.action, p.num_a, p.den_a, p.num_b, p.den_b, (i % 180) == 90);
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (send_q.size() == 0);
        @(posedge i_clk);
        while (in_ch.valid || reduced_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (n_err == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/ranm_pkg.sv
rtl/core/ranm_if.sv
rtl/core/ranm_dp.sv
rtl/core/ranm_ctrl.sv
rtl/core/rational_add_mult_normalize.sv
tb/sv/tb_ranm_types.sv
tb/sv/tb.sv
